@@ src/nacf_pkg.sv @@
`default_nettype none

package nacf_pkg;

	// Packet fields that an upstream parser extracted.
	typedef struct packed {
		logic [15:0] packet_length;
		logic [7:0]  ver_ihl_byte;
		logic [15:0] frag_word;
		logic [7:0]  ip_protocol;
		logic [15:0] ip_checksum;
		logic [15:0] l4_checksum;
		logic [31:0] old_addr;
		logic [31:0] new_addr;
	} nacf_in_t;

	// One fixup result.
	typedef struct packed {
		logic [15:0] ip_checksum_out;
		logic [15:0] l4_checksum_out;
		logic        l4_updated;
		logic [1:0]  status;
	} nacf_out_t;

	typedef logic [1:0] nacf_status_t;

	localparam nacf_status_t STAT_OK       = 2'd0;
	localparam nacf_status_t STAT_SHORT    = 2'd1;
	localparam nacf_status_t STAT_IHL_LONG = 2'd2;
	localparam nacf_status_t STAT_L4_SHORT = 2'd3;

	localparam logic [15:0] IPV4_HDR_LEN  = 16'd20;
	localparam logic [15:0] TCP_HDR_LEN   = 16'd20;
	localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [15:0] FRAG_OFF_MASK = 16'h1FFF;

endpackage : nacf_pkg

`default_nettype wire

@@ src/nat_address_checksum_fixup.sv @@
`default_nettype none

// Channel     Ports          Handshake
// ---------   ------------   ------------------------------------------------
// packet in   pkt            taken at a rising edge with start high, busy low
// result out  result         valid for one cycle while done is high
//
// Every packet yields exactly one result, after it has passed through every pipeline stage.
// A new packet can be taken in every cycle; busy is always low, since the
// pipeline never has to wait for the receiver.
// Reset (arst_n low) clears the stage valid bits, so no stray result appears.
// The receiver cannot stall, so results leave in the order packets came in.

module nat_address_checksum_fixup
	import nacf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire nacf_in_t  pkt,
	output logic           done,
	output nacf_out_t      result
);

	// Stage 1 computes the address difference that both checksums share,
	// (old_hi + old_lo) - (new_hi + new_lo), and decides from the length,
	// header length, fragment offset and protocol which checksums change
	// and what status the packet gets.
	logic signed [18:0] delta;
	logic [5:0]         hdr_bytes;
	logic [15:0]        payload_len;
	logic               ip_adj;
	logic               l4_adj;
	nacf_status_t       status_d;
	logic               accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign delta = $signed({3'b000, pkt.old_addr[31:16]})
		+ $signed({3'b000, pkt.old_addr[15:0]})
		- $signed({3'b000, pkt.new_addr[31:16]})
		- $signed({3'b000, pkt.new_addr[15:0]});

	assign hdr_bytes   = {pkt.ver_ihl_byte[3:0], 2'b00};
	assign payload_len = pkt.packet_length - {10'd0, hdr_bytes};

	always_comb begin
		ip_adj   = 1'b0;
		l4_adj   = 1'b0;
		status_d = STAT_OK;
		priority if (pkt.packet_length < IPV4_HDR_LEN) begin
			status_d = STAT_SHORT;
		end else if ({10'd0, hdr_bytes} > pkt.packet_length) begin
			ip_adj   = 1'b1;
			status_d = STAT_IHL_LONG;
		end else begin
			ip_adj = 1'b1;
			// Only the first fragment (offset zero) carries the L4 header.
			if ((pkt.frag_word & FRAG_OFF_MASK) == 16'd0) begin
				if (pkt.ip_protocol == PROTO_TCP) begin
					if (payload_len < TCP_HDR_LEN) begin
						status_d = STAT_L4_SHORT;
					end else begin
						l4_adj = 1'b1;
					end
				end else if (pkt.ip_protocol == PROTO_UDP) begin
					if (payload_len < UDP_HDR_LEN) begin
						status_d = STAT_L4_SHORT;
					end else if (pkt.l4_checksum != 16'd0) begin
						// A zero UDP checksum means none was sent; keep it.
						l4_adj = 1'b1;
					end
				end
			end
		end
	end

	logic               valid_s1;
	logic signed [18:0] delta_s1;
	logic [15:0]        ipck_s1;
	logic [15:0]        l4ck_s1;
	logic               ip_adj_s1;
	logic               l4_adj_s1;
	nacf_status_t       status_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		delta_s1  <= delta;
		ipck_s1   <= pkt.ip_checksum;
		l4ck_s1   <= pkt.l4_checksum;
		ip_adj_s1 <= ip_adj;
		l4_adj_s1 <= l4_adj;
		status_s1 <= status_d;
	end

	// Stage 2 adds the difference to each checksum. The sum lies between
	// -131070 and 196605, so its magnitude fits in 18 bits; a negative sum
	// is kept as magnitude and sign.
	logic signed [18:0] acc_ip;
	logic signed [18:0] acc_l4;
	logic signed [18:0] abs_ip;
	logic signed [18:0] abs_l4;

	assign acc_ip = $signed({3'b000, ipck_s1}) + delta_s1;
	assign acc_l4 = $signed({3'b000, l4ck_s1}) + delta_s1;
	assign abs_ip = acc_ip[18] ? -acc_ip : acc_ip;
	assign abs_l4 = acc_l4[18] ? -acc_l4 : acc_l4;

	logic         valid_s2;
	logic [17:0]  mag_ip_s2;
	logic [17:0]  mag_l4_s2;
	logic         neg_ip_s2;
	logic         neg_l4_s2;
	logic [15:0]  ipck_s2;
	logic [15:0]  l4ck_s2;
	logic         ip_adj_s2;
	logic         l4_adj_s2;
	nacf_status_t status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_ip_s2 <= abs_ip[17:0];
		mag_l4_s2 <= abs_l4[17:0];
		neg_ip_s2 <= acc_ip[18];
		neg_l4_s2 <= acc_l4[18];
		ipck_s2   <= ipck_s1;
		l4ck_s2   <= l4ck_s1;
		ip_adj_s2 <= ip_adj_s1;
		l4_adj_s2 <= l4_adj_s1;
		status_s2 <= status_s1;
	end

	// Stage 3 folds the carries into 16 bits twice, complements the result
	// of a negative sum, and picks adjusted or original checksums.
	logic [16:0] fold1_ip;
	logic [16:0] fold1_l4;
	logic [15:0] fold2_ip;
	logic [15:0] fold2_l4;
	logic [15:0] new_ip;
	logic [15:0] new_l4;

	assign fold1_ip = {15'd0, mag_ip_s2[17:16]} + {1'b0, mag_ip_s2[15:0]};
	assign fold1_l4 = {15'd0, mag_l4_s2[17:16]} + {1'b0, mag_l4_s2[15:0]};
	assign fold2_ip = fold1_ip[15:0] + {15'd0, fold1_ip[16]};
	assign fold2_l4 = fold1_l4[15:0] + {15'd0, fold1_l4[16]};
	assign new_ip   = neg_ip_s2 ? ~fold2_ip : fold2_ip;
	assign new_l4   = neg_l4_s2 ? ~fold2_l4 : fold2_l4;

	logic      valid_s3;
	nacf_out_t res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		res_s3.ip_checksum_out <= ip_adj_s2 ? new_ip : ipck_s2;
		res_s3.l4_checksum_out <= l4_adj_s2 ? new_l4 : l4ck_s2;
		res_s3.l4_updated      <= l4_adj_s2;
		res_s3.status          <= status_s2;
	end

	assign done   = valid_s3;
	assign result = res_s3;

	// Every result stems from a taken packet that has passed through every stage.
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result without a packet taken three cycles before");

	// A taken packet always yields a result once it has passed through every stage.
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("packet taken but no result three cycles later");

	// An adjusted L4 checksum only goes with a clean status.
	a_upd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.l4_updated) |-> (result.status == STAT_OK))
		else $error("L4 checksum adjusted on a packet with a length error");

	// A packet shorter than an IPv4 header keeps its IP checksum.
	a_short_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STAT_SHORT)
		|-> (result.ip_checksum_out == $past(pkt.ip_checksum, 3)))
		else $error("short packet had its IP checksum changed");

endmodule : nat_address_checksum_fixup

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the NAT checksum fixup pipeline.
//
// Packets go in over the start/busy handshake, one transaction per accepted
// edge, and every result comes back on done for a single cycle. The result
// cannot be held off, so the scoreboard only has to keep expectations in
// arrival order. It compares each result against the oldest one waiting.
//
// The run has two parts. A short directed table comes first. It covers the
// length extremes, every status code, IHL values at and beyond the packet
// length, fragments, both L4 protocols with their short-payload limits, the
// UDP "no checksum" value, and the largest positive and negative
// accumulator sums. After that, roughly a thousand random packets follow.
// Most of them are shaped like real headers, with lengths near the header
// and payload limits, so that the deeper branches are reached often.
module testbench;
	import nacf_pkg::*;

	localparam int RANDOM_PACKETS = 1050;
	localparam int CALM_TAIL      = 150;	// last random packets sent back to back
	localparam int MAX_REPORTS    = 200;

	// One row of the directed table. Where typed is set, want holds a result
	// that is obvious from the inputs; otherwise the predictor supplies it.
	typedef struct packed {
		nacf_in_t  pkt;
		logic      typed;
		nacf_out_t want;
	} fixup_vector_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	nacf_in_t  pkt    = '0;
	logic      busy;
	logic      done;
	nacf_out_t result;

	// These travel with pkt, so the scoreboard knows which expectation to use
	// for the transaction it sees accepted.
	logic      tx_typed = 1'b0;
	nacf_out_t tx_want  = '0;

	fixup_vector_t directed[$];
	nacf_out_t     pending_fixups[$];

	int mismatch_count = 0;
	int results_seen   = 0;
	int l4_fixed_count = 0;
	int status_seen[4] = '{0, 0, 0, 0};

	nat_address_checksum_fixup dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pkt    (pkt),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Incremental one's-complement adjustment for swapping old_a for new_a.
	// The sum is kept signed. A negative sum is folded as a magnitude and
	// then complemented, which is what the hardware is meant to do.
	function automatic logic [15:0] csum_adjust(input logic [15:0] csum,
			input logic [31:0] old_a, input logic [31:0] new_a);
		int          acc;
		logic [31:0] mag;
		logic [31:0] folded;
		acc = int'(csum) - int'(new_a[31:16]) - int'(new_a[15:0])
			+ int'(old_a[31:16]) + int'(old_a[15:0]);
		mag = (acc < 0) ? 32'(-acc) : 32'(acc);
		folded = (mag >> 16) + (mag & 32'h0000_FFFF);
		folded = folded + (folded >> 16);
		return (acc < 0) ? ~folded[15:0] : folded[15:0];
	endfunction

	// Expected result for one packet.
	function automatic nacf_out_t fixup_predict(input nacf_in_t p);
		nacf_out_t   o;
		logic [16:0] hdr_bytes;
		logic [16:0] payload;
		o.ip_checksum_out = p.ip_checksum;
		o.l4_checksum_out = p.l4_checksum;
		o.l4_updated      = 1'b0;
		o.status          = STAT_OK;
		if (p.packet_length < IPV4_HDR_LEN) begin
			o.status = STAT_SHORT;
		end else begin
			// The IP header checksum is fixed whenever a header fits.
			hdr_bytes = {11'd0, p.ver_ihl_byte[3:0], 2'b00};
			o.ip_checksum_out = csum_adjust(p.ip_checksum, p.old_addr, p.new_addr);
			if (hdr_bytes > {1'b0, p.packet_length}) begin
				o.status = STAT_IHL_LONG;
			end else if ((p.frag_word & FRAG_OFF_MASK) == 16'd0) begin
				// Only the first fragment carries the L4 header.
				payload = {1'b0, p.packet_length} - hdr_bytes;
				if (p.ip_protocol == PROTO_TCP) begin
					if (payload < {1'b0, TCP_HDR_LEN}) begin
						o.status = STAT_L4_SHORT;
					end else begin
						o.l4_checksum_out = csum_adjust(p.l4_checksum, p.old_addr,
							p.new_addr);
						o.l4_updated = 1'b1;
					end
				end else if (p.ip_protocol == PROTO_UDP) begin
					if (payload < {1'b0, UDP_HDR_LEN}) begin
						o.status = STAT_L4_SHORT;
					end else if (p.l4_checksum != 16'd0) begin
						// A zero UDP checksum means "none" and stays zero.
						o.l4_checksum_out = csum_adjust(p.l4_checksum, p.old_addr,
							p.new_addr);
						o.l4_updated = 1'b1;
					end
				end
			end
		end
		return o;
	endfunction

	function automatic void add_vector(input logic [15:0] len, input logic [7:0] ver_ihl,
			input logic [15:0] frag, input logic [7:0] proto, input logic [15:0] ip_ck,
			input logic [15:0] l4_ck, input logic [31:0] old_a, input logic [31:0] new_a,
			input logic typed, input nacf_out_t want);
		fixup_vector_t v;
		v.pkt   = {len, ver_ihl, frag, proto, ip_ck, l4_ck, old_a, new_a};
		v.typed = typed;
		v.want  = want;
		directed.push_back(v);
	endfunction

	// Present one packet and return at the edge that accepts it. The caller
	// either presents the next packet at that same edge or lowers start.
	task automatic send_packet(input nacf_in_t p, input logic typed, input nacf_out_t want);
		pkt      <= p;
		tx_typed <= typed;
		tx_want  <= want;
		start    <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stop sending and wait until every outstanding transaction has returned.
	// The first edge lets the scoreboard record the packet that was just
	// accepted.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_fixups.size() != 0) @(posedge clk);
	endtask

	// Scoreboard. All inputs and outputs change only just after an edge, so
	// the values seen here are those that held before the edge.
	always @(posedge clk) begin : scoreboard
		nacf_out_t want;
		if (done) begin
			if (pending_fixups.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with no transaction outstanding: actual %h",
						$time, result);
			end else begin
				want = pending_fixups.pop_front();
				results_seen++;
				if (result.l4_updated) l4_fixed_count++;
				status_seen[result.status]++;
				if (result !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: expected ip %h l4 %h upd %b st %0d, actual ip %h l4 %h upd %b st %0d",
							$time,
							want.ip_checksum_out, want.l4_checksum_out,
							want.l4_updated, want.status, result.ip_checksum_out,
							result.l4_checksum_out, result.l4_updated, result.status);
				end
			end
		end
		if (start && !busy)
			pending_fixups.push_back(tx_typed ? tx_want : fixup_predict(pkt));
	end

	// Stimulus.
	initial begin : stimulus
		nacf_in_t r;
		int       idle_pct;
		int       pick;
		int       ihl_words;
		int       l4_hdr;
		int       len_i;

		// Directed table. Short packets pass everything through. When the old
		// and new addresses match, the checksum comes back unchanged.
		add_vector(16'd0, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000, 32'h0, 32'h0,
			1'b1, {16'h0000, 16'h0000, 1'b0, STAT_SHORT});
		add_vector(16'd19, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0,
			1'b1, {16'hFFFF, 16'hFFFF, 1'b0, STAT_SHORT});
		add_vector(16'd20, 8'h45, 16'h0000, PROTO_TCP, 16'h1234, 16'h5678,
			32'hC0A8_0001, 32'hC0A8_0001, 1'b1, {16'h1234, 16'h5678, 1'b0, STAT_L4_SHORT});
		add_vector(16'd100, 8'h45, 16'h0000, PROTO_TCP, 16'h0000, 16'h0000, 32'h0, 32'h0,
			1'b1, {16'h0000, 16'h0000, 1'b1, STAT_OK});
		// IHL just past the length, and IHL values below the minimum.
		add_vector(16'd20, 8'h46, 16'h0000, PROTO_TCP, 16'hB1C2, 16'h3344,
			32'h0A00_0001, 32'hCB00_7101, 1'b0, '0);
		add_vector(16'd20, 8'h40, 16'h0000, PROTO_TCP, 16'h7E01, 16'h9A0F,
			32'h0A00_0002, 32'h6440_0001, 1'b0, '0);
		add_vector(16'd20, 8'h41, 16'h0000, PROTO_TCP, 16'h7E01, 16'h9A0F,
			32'h0A00_0002, 32'h6440_0001, 1'b0, '0);
		// Largest IHL, with a TCP payload that is empty and then exactly full.
		add_vector(16'd60, 8'h4F, 16'h0000, PROTO_TCP, 16'h1111, 16'h2222,
			32'hAC10_0005, 32'h0808_0808, 1'b0, '0);
		add_vector(16'd80, 8'h4F, 16'h0000, PROTO_TCP, 16'h1111, 16'h2222,
			32'hAC10_0005, 32'h0808_0808, 1'b0, '0);
		// Largest positive and most negative accumulator sums, and a sum of -1.
		add_vector(16'hFFFF, 8'hFF, 16'h0000, PROTO_TCP, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'h0, 1'b0, '0);
		add_vector(16'hFFFF, 8'h45, 16'h0000, PROTO_UDP, 16'h0000, 16'h0001,
			32'h0, 32'hFFFF_FFFF, 1'b0, '0);
		add_vector(16'd60, 8'h45, 16'h0000, PROTO_TCP, 16'h0000, 16'h0000,
			32'h0, 32'h0000_0001, 1'b0, '0);
		// Fragment handling: flags alone do not block the L4 fixup.
		add_vector(16'd40, 8'h45, 16'h4000, PROTO_TCP, 16'h5A5A, 16'hA5A5,
			32'hC0A8_010A, 32'h5DB8_D822, 1'b0, '0);
		add_vector(16'd40, 8'h45, 16'hE000, PROTO_TCP, 16'h5A5A, 16'hA5A5,
			32'hC0A8_010A, 32'h5DB8_D822, 1'b0, '0);
		add_vector(16'd40, 8'h45, 16'h0001, PROTO_TCP, 16'h5A5A, 16'hA5A5,
			32'hC0A8_010A, 32'h5DB8_D822, 1'b0, '0);
		add_vector(16'd40, 8'h45, 16'h1FFF, PROTO_UDP, 16'h5A5A, 16'hA5A5,
			32'hC0A8_010A, 32'h5DB8_D822, 1'b0, '0);
		// UDP: payload exactly at the limit, one short, zero and all-ones checksum.
		add_vector(16'd28, 8'h45, 16'h0000, PROTO_UDP, 16'hCAFE, 16'hBEEF,
			32'h0A01_0203, 32'hC633_6401, 1'b0, '0);
		add_vector(16'd27, 8'h45, 16'h0000, PROTO_UDP, 16'hCAFE, 16'hBEEF,
			32'h0A01_0203, 32'hC633_6401, 1'b0, '0);
		add_vector(16'd100, 8'h45, 16'h0000, PROTO_UDP, 16'hCAFE, 16'h0000,
			32'h0A01_0203, 32'hC633_6401, 1'b0, '0);
		add_vector(16'd100, 8'h45, 16'h0000, PROTO_UDP, 16'hCAFE, 16'hFFFF,
			32'h0A01_0203, 32'hC633_6401, 1'b0, '0);
		// Other protocols, and a version nibble that the block ignores.
		add_vector(16'd100, 8'h45, 16'h0000, 8'd1, 16'h0F0F, 16'hF0F0,
			32'h7F00_0001, 32'h0A0A_0A0A, 1'b0, '0);
		add_vector(16'd100, 8'h45, 16'h0000, 8'hFF, 16'h0F0F, 16'hF0F0,
			32'h7F00_0001, 32'h0A0A_0A0A, 1'b0, '0);
		add_vector(16'd100, 8'hF5, 16'h0000, PROTO_TCP, 16'h0F0F, 16'hF0F0,
			32'h7F00_0001, 32'h0A0A_0A0A, 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i]) begin
			send_packet(directed[i].pkt, directed[i].typed, directed[i].want);
			if ($urandom_range(99) < 25) idle_cycles($urandom_range(1, 16));
		end
		drain_results();

		idle_pct = 0;
		for (int n = 0; n < RANDOM_PACKETS; n++) begin
			// The idle rate changes every 50 packets, with some stretches
			// of none, and the final stretch runs at full rate.
			if (n % 50 == 0) begin
				pick = $urandom_range(3);
				idle_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 20 : 50;
			end
			if (n >= RANDOM_PACKETS - CALM_TAIL) idle_pct = 0;
			// Once in the middle, let the pipeline run completely dry.
			if (n == RANDOM_PACKETS / 2) drain_results();

			r.ver_ihl_byte = 8'($urandom);
			r.ip_checksum  = 16'($urandom);
			r.l4_checksum  = 16'($urandom);
			r.old_addr     = $urandom;
			r.new_addr     = $urandom;
			if ($urandom_range(99) < 15) begin
				// Raw noise over the full range of every field.
				r.packet_length = 16'($urandom);
				r.frag_word     = 16'($urandom);
				r.ip_protocol   = 8'($urandom);
			end else begin
				ihl_words = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(5, 15);
				r.ver_ihl_byte[3:0] = 4'(ihl_words);
				pick = $urandom_range(99);
				r.ip_protocol = (pick < 45) ? PROTO_TCP : (pick < 85) ? PROTO_UDP
					: 8'($urandom);
				l4_hdr = (r.ip_protocol == PROTO_UDP) ? 8 : 20;
				pick = $urandom_range(99);
				if (pick < 40)
					len_i = ihl_words * 4 + l4_hdr + $urandom_range(4) - 2;
				else if (pick < 70)
					len_i = $urandom_range(20, 1500);
				else if (pick < 90)
					len_i = $urandom_range(20, 65535);
				else
					len_i = $urandom_range(20, 60);
				if (len_i < 0) len_i = 0;
				r.packet_length = 16'(len_i);
				r.frag_word = ($urandom_range(99) < 75) ? {3'($urandom), 13'd0}
					: 16'($urandom);
				if ($urandom_range(99) < 8) r.l4_checksum = 16'h0000;
				pick = $urandom_range(99);
				if (pick < 5) begin
					r.new_addr = r.old_addr;
				end else if (pick < 10) begin
					r.old_addr = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
					r.new_addr = ~r.old_addr;
					r.ip_checksum = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				end
			end
			send_packet(r, 1'b0, '0);
			if ($urandom_range(99) < idle_pct) idle_cycles($urandom_range(1, 16));
		end

		drain_results();
		repeat (8) @(posedge clk);

		$display("Ran %0d directed and %0d random packets; %0d checked, L4 fixed %0d.",
			directed.size(), RANDOM_PACKETS, results_seen, l4_fixed_count);
		$display("Status mix: ok %0d, short %0d, IHL long %0d, L4 short %0d; %0d errors.",
			status_seen[STAT_OK], status_seen[STAT_SHORT], status_seen[STAT_IHL_LONG],
			status_seen[STAT_L4_SHORT], mismatch_count);
		if (mismatch_count == 0 && pending_fixups.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// This allows far more time than the slowest correct run takes.
	initial begin : watchdog
		#2_000_000;
		$display("Timed out with %0d results outstanding.", pending_fixups.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
